// ===== rtl/cache_line_flush_skip_tracker_unit_macros.svh =====
// Assertion macros shared by the cache line flush/skip tracker RTL.
`ifndef CACHE_LINE_FLUSH_SKIP_TRACKER_UNIT_MACROS_SVH
`define CACHE_LINE_FLUSH_SKIP_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CFST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CFST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfst_pkg.sv =====
// Types and constants of the cache line flush/skip tracker.
package cfst_pkg;

    localparam int LINES_DEF = 256;
    localparam int IDX_W     = 8;
    localparam int DATA_W    = 32;
    localparam int REPS_W    = 16;
    localparam int CNT_W     = 32;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 248;

    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_READ      = 3'd1,
        OP_FLUSH     = 3'd2,
        OP_CLEAN     = 3'd3,
        OP_EVICT     = 3'd4,
        OP_REP_FLUSH = 3'd5,
        OP_RESET_ALL = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic skip;
        logic dirty;
    } line_flags_t;

    typedef struct packed {
        logic              clear;
        logic              clean_inc;
        logic              evict_inc;
        logic              hit_inc;
        logic              miss_inc;
        logic [REPS_W-1:0] flush_add;
        logic [REPS_W-1:0] skip_add;
    } cnt_upd_t;

    typedef struct packed {
        logic [CNT_W-1:0] miss;
        logic [CNT_W-1:0] hit;
        logic [CNT_W-1:0] skipped;
        logic [CNT_W-1:0] evict;
        logic [CNT_W-1:0] clean;
        logic [CNT_W-1:0] flush;
    } cnt_totals_t;

endpackage

// ===== rtl/cfst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/cfst_counters.sv =====
// Six wrapping event counters of the tracker; presents post-update totals.
module cfst_counters (
    input  logic                   clk,
    input  logic                   rstn,
    input  cfst_pkg::cnt_upd_t     upd,
    output cfst_pkg::cnt_totals_t  totals_next
);
    import cfst_pkg::*;

`include "cache_line_flush_skip_tracker_unit_macros.svh"

    cnt_totals_t cnt_reg;
    logic        upd_any;

    assign upd_any = upd.clear | upd.clean_inc | upd.evict_inc | upd.hit_inc | upd.miss_inc
                   | (|upd.flush_add) | (|upd.skip_add);

    always_comb begin
        if (upd.clear) begin
            totals_next = '0;
        end else begin
            totals_next.flush   = cnt_reg.flush + {{(CNT_W-REPS_W){1'b0}}, upd.flush_add};
            totals_next.skipped = cnt_reg.skipped + {{(CNT_W-REPS_W){1'b0}}, upd.skip_add};
            totals_next.clean   = cnt_reg.clean + CNT_W'(upd.clean_inc);
            totals_next.evict   = cnt_reg.evict + CNT_W'(upd.evict_inc);
            totals_next.hit     = cnt_reg.hit + CNT_W'(upd.hit_inc);
            totals_next.miss    = cnt_reg.miss + CNT_W'(upd.miss_inc);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= totals_next;
        end
    end

    `CFST_ASSERT_NEXT(a_clear_zeroes, clk, rstn, upd.clear, cnt_reg == '0, "counters not cleared")
    `CFST_ASSERT_NEXT(a_idle_holds, clk, rstn, !upd_any, $stable(cnt_reg), "counter moved idle")
    `CFST_ASSERT_NEXT(a_hit_step, clk, rstn, upd.hit_inc && !upd.clear,
                      cnt_reg.hit == $past(cnt_reg.hit) + 32'd1, "hit count step wrong")

endmodule

// ===== rtl/cache_line_flush_skip_tracker_unit.sv =====
// Cache line flush/skip tracker: top level with line memories, control FSM and result register.
// A request's line is read as it is accepted; its result is registered in the execute state,
//   which holds while the result channel stalls. A new request is taken only back in idle,
//   after the line has been written back in the execute state.
// Reset (aresetn low, synchronous): a sweep over every line zeroes line data and flags; no
//   request is accepted meanwhile. A reset-all request starts a sweep of the flags alone.
module cache_line_flush_skip_tracker_unit #(
    parameter int LINES = cfst_pkg::LINES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] line_index, [39:8] write_value, [40] use_skip, [56:41] repeat_count
    input  logic [cfst_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] operation
    input  logic [cfst_pkg::S_TUSER_W-1:0] s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] read_data, [32] performed, [48:33] performed_count, [80:49] flush_total,
    // [112:81] clean_total, [144:113] evict_total, [176:145] skipped_total,
    // [208:177] hit_total, [240:209] miss_total
    output logic [cfst_pkg::M_TDATA_W-1:0] m_tdata
);
    import cfst_pkg::*;

`include "cache_line_flush_skip_tracker_unit_macros.svh"

    localparam int AW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [AW-1:0] LAST_LINE = AW'(LINES - 1);
    localparam logic [16:0]   LINES_W   = 17'(LINES);

    // ---------------- state ----------------
    state_t              state_reg, state_next;
    logic [AW-1:0]       sweep_reg;
    logic                clear_data_reg;   // power-on sweep also zeroes data words

    // latched request
    logic [2:0]          op_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [DATA_W-1:0]   wval_reg;
    logic                skip_en_reg;
    logic [REPS_W-1:0]   reps_reg;

    // result register
    logic                m_valid_reg;
    logic [DATA_W-1:0]   rdata_out_reg;
    logic                performed_reg;
    logic [REPS_W-1:0]   pcount_reg;
    cnt_totals_t         totals_reg;

    // ---------------- request decode ----------------
    logic                s_accept;
    logic [IDX_W-1:0]    s_idx;
    logic [AW-1:0]       s_addr;
    logic [AW-1:0]       req_addr;
    logic                in_range;
    logic                exec_fire;

    assign s_accept  = s_tvalid && s_tready;
    assign s_idx     = s_tdata[7:0];
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    // line index onto memory address (zero-extend or truncate to AW bits)
    always_comb begin
        logic [AW+IDX_W-1:0] ext_s;
        logic [AW+IDX_W-1:0] ext_r;
        ext_s    = {{AW{1'b0}}, s_idx};
        ext_r    = {{AW{1'b0}}, idx_reg};
        s_addr   = ext_s[AW-1:0];
        req_addr = ext_r[AW-1:0];
    end

    assign in_range = ({9'd0, idx_reg} < LINES_W);

    // ---------------- line memories ----------------
    logic                ram_re;
    logic                data_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   data_wdata;
    logic [DATA_W-1:0]   data_rdata;
    logic                flags_we;
    line_flags_t         flags_wdata;
    logic [1:0]          flags_rdata_raw;
    line_flags_t         flags_rd;

    cfst_ram #(.WIDTH(DATA_W), .DEPTH(LINES)) u_data_ram (
        .clk   (aclk),
        .we    (data_we),
        .waddr (ram_waddr),
        .wdata (data_wdata),
        .re    (ram_re),
        .raddr (s_addr),
        .rdata (data_rdata)
    );

    cfst_ram #(.WIDTH(2), .DEPTH(LINES)) u_flags_ram (
        .clk   (aclk),
        .we    (flags_we),
        .waddr (ram_waddr),
        .wdata (flags_wdata),
        .re    (ram_re),
        .raddr (s_addr),
        .rdata (flags_rdata_raw)
    );

    assign flags_rd = line_flags_t'(flags_rdata_raw);

    // ---------------- counters ----------------
    cnt_upd_t            cnt_upd;
    cnt_totals_t         totals_next;

    cfst_counters u_counters (
        .clk         (aclk),
        .rstn        (aresetn),
        .upd         (cnt_upd),
        .totals_next (totals_next)
    );

    // ---------------- operation logic (read-modify-write of one line) ----------------
    logic                exec_data_we;
    logic                exec_flags_we;
    line_flags_t         exec_flags;
    cnt_upd_t            exec_upd;
    logic [DATA_W-1:0]   exec_rdata;
    logic                exec_performed;
    logic [REPS_W-1:0]   exec_pcount;
    logic                redundant;

    assign redundant = skip_en_reg && !flags_rd.dirty && flags_rd.skip;

    always_comb begin
        exec_data_we   = 1'b0;
        exec_flags_we  = 1'b0;
        exec_flags     = '0;
        exec_upd       = '0;
        exec_rdata     = '0;
        exec_performed = 1'b0;
        exec_pcount    = '0;
        if (op_reg == OP_RESET_ALL) begin
            exec_upd.clear = 1'b1;
        end else if (in_range) begin
            case (op_reg)
                OP_WRITE: begin
                    exec_data_we     = 1'b1;
                    exec_flags_we    = 1'b1;
                    exec_flags.dirty = 1'b1;
                end
                OP_READ: begin
                    exec_rdata        = data_rdata;
                    exec_upd.miss_inc = flags_rd.dirty;
                    exec_upd.hit_inc  = !flags_rd.dirty;
                end
                OP_FLUSH, OP_CLEAN: begin
                    if (redundant) begin
                        exec_upd.skip_add = REPS_W'(1);
                    end else begin
                        exec_flags_we   = 1'b1;
                        exec_flags.skip = 1'b1;
                        exec_performed  = 1'b1;
                        if (op_reg == OP_FLUSH) begin
                            exec_upd.flush_add = REPS_W'(1);
                        end else begin
                            exec_upd.clean_inc = 1'b1;
                        end
                    end
                end
                OP_EVICT: begin
                    exec_flags_we      = 1'b1;
                    exec_upd.evict_inc = 1'b1;
                end
                OP_REP_FLUSH: begin
                    // closed form: all carried out without skip; with skip at most the first
                    if (reps_reg != '0) begin
                        if (!skip_en_reg) begin
                            exec_pcount = reps_reg;
                        end else if (redundant) begin
                            exec_pcount = '0;
                        end else begin
                            exec_pcount = REPS_W'(1);
                        end
                        exec_performed     = (exec_pcount != '0);
                        exec_flags_we      = exec_performed;
                        exec_flags.skip    = 1'b1;
                        exec_upd.flush_add = exec_pcount;
                        exec_upd.skip_add  = reps_reg - exec_pcount;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- FSM: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sweep_reg == LAST_LINE) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next = (op_reg == OP_RESET_ALL) ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- FSM: outputs ----------------
    always_comb begin
        s_tready    = 1'b0;
        ram_re      = 1'b0;
        data_we     = 1'b0;
        data_wdata  = wval_reg;
        flags_we    = 1'b0;
        flags_wdata = exec_flags;
        ram_waddr   = req_addr;
        cnt_upd     = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_waddr   = sweep_reg;
                flags_we    = 1'b1;
                flags_wdata = '0;
                data_we     = clear_data_reg;
                data_wdata  = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_re   = s_tvalid;
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    data_we  = exec_data_we;
                    flags_we = exec_flags_we;
                    cnt_upd  = exec_upd;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            clear_data_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                sweep_reg <= sweep_reg + AW'(1);
                if (sweep_reg == LAST_LINE) begin
                    clear_data_reg <= 1'b0;
                end
            end else if (exec_fire) begin
                sweep_reg <= '0;
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg      <= s_tuser[2:0];
            idx_reg     <= s_idx;
            wval_reg    <= s_tdata[39:8];
            skip_en_reg <= s_tdata[40];
            reps_reg    <= s_tdata[56:41];
        end
        if (exec_fire) begin
            rdata_out_reg <= exec_rdata;
            performed_reg <= exec_performed;
            pcount_reg    <= exec_pcount;
            totals_reg    <= totals_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, totals_reg.miss, totals_reg.hit, totals_reg.skipped,
                       totals_reg.evict, totals_reg.clean, totals_reg.flush,
                       pcount_reg, performed_reg, rdata_out_reg};

    // ---------------- assertions ----------------
    `CFST_ASSERT_NEXT(a_accept_to_exec, aclk, aresetn, s_accept, state_reg == ST_EXEC,
                      "accepted request did not enter execute")
    `CFST_ASSERT_NEXT(a_reset_all_sweeps, aclk, aresetn, exec_fire && op_reg == OP_RESET_ALL,
                      state_reg == ST_CLEAR && sweep_reg == '0, "reset-all did not start sweep")
    `CFST_ASSERT_NEXT(a_result_from_exec, aclk, aresetn, !m_valid_reg && state_reg != ST_EXEC,
                      !m_valid_reg, "result appeared without execute")
    `CFST_ASSERT_NOW(a_no_write_in_idle, aclk, aresetn, state_reg == ST_IDLE,
                     !data_we && !flags_we, "line memory written while idle")

endmodule
